[src/wav_header_parser_core_assert.svh]
// Assertion shorthands, clocked on i_clk and idle while i_rst_n is low.
`ifndef WAV_HEADER_PARSER_CORE_ASSERT_SVH
`define WAV_HEADER_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define WHP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WHP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/wavhp_pkg.sv]
package wavhp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT   = 32'h666d_7420;
    localparam logic [31:0] ID_DATA  = 32'h6461_7461;

    localparam logic [15:0] CODEC_PCM   = 16'h0001;
    localparam logic [15:0] CODEC_FLOAT = 16'h0003;
    localparam logic [15:0] CODEC_ALAW  = 16'h0006;
    localparam logic [15:0] CODEC_ULAW  = 16'h0007;
    localparam logic [15:0] EXT_FULL    = 16'd22;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_ERROR  = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;

    localparam logic [1:0] ERR_NOT_RIFF = 2'd0;
    localparam logic [1:0] ERR_NOT_WAVE = 2'd1;
    localparam logic [1:0] ERR_FORMAT   = 2'd2;

    localparam logic [3:0] FMT_MONO8   = 4'd0;
    localparam logic [3:0] FMT_MONO16  = 4'd1;
    localparam logic [3:0] FMT_STEREO8 = 4'd2;
    localparam logic [3:0] FMT_STEREO16 = 4'd3;
    localparam logic [3:0] FMT_F32     = 4'd4;
    localparam logic [3:0] FMT_ALAW    = 4'd6;
    localparam logic [3:0] FMT_ULAW    = 4'd8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       file_start;
    } t_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [3:0]  format_code;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] sample_bits;
        logic [31:0] data_length;
        logic [7:0]  data_byte;
        logic [1:0]  error_code;
    } t_result;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

[src/wavhp_parser.sv]
module wavhp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  wavhp_pkg::t_item  i_item,
    output logic              o_wr,
    output wavhp_pkg::t_result o_res
);
    import wavhp_pkg::*;

    localparam logic [3:0] PH_RIFF     = 4'd0;
    localparam logic [3:0] PH_RSIZE    = 4'd1;
    localparam logic [3:0] PH_WAVE     = 4'd2;
    localparam logic [3:0] PH_ID       = 4'd3;
    localparam logic [3:0] PH_SZ_FMT   = 4'd4;
    localparam logic [3:0] PH_SZ_DATA  = 4'd5;
    localparam logic [3:0] PH_SZ_OTHER = 4'd6;
    localparam logic [3:0] PH_FMT      = 4'd7;
    localparam logic [3:0] PH_SKIP     = 4'd8;
    localparam logic [3:0] PH_DATA     = 4'd9;

    typedef struct packed {
        logic       ok;
        logic [3:0] code;
    } t_fmt_chk;

    function automatic logic [15:0] set16(input logic [15:0] v, input logic hi,
                                          input logic [7:0] b);
        logic [15:0] r;
        r = v;
        if (hi) r[15:8] = b;
        else    r[7:0]  = b;
        return r;
    endfunction

    function automatic logic [31:0] set32(input logic [31:0] v, input logic [1:0] idx,
                                          input logic [7:0] b);
        logic [31:0] r;
        r = v;
        case (idx)
            2'd0:    r[7:0]   = b;
            2'd1:    r[15:8]  = b;
            2'd2:    r[23:16] = b;
            default: r[31:24] = b;
        endcase
        return r;
    endfunction

    function automatic t_fmt_chk classify(input logic [15:0] ch, input logic [15:0] codec,
                                          input logic [15:0] bits);
        t_fmt_chk r;
        logic     st;
        r  = '0;
        st = (ch == 16'd2);
        if (ch == 16'd1 || ch == 16'd2) begin
            case (codec)
                CODEC_PCM: begin
                    if (bits == 16'd8) begin
                        r.ok   = 1'b1;
                        r.code = st ? FMT_STEREO8 : FMT_MONO8;
                    end else if (bits == 16'd16) begin
                        r.ok   = 1'b1;
                        r.code = st ? FMT_STEREO16 : FMT_MONO16;
                    end
                end
                CODEC_FLOAT: begin
                    r.ok   = (bits == 16'd32);
                    r.code = FMT_F32 + {3'd0, st};
                end
                CODEC_ALAW: begin
                    r.ok   = 1'b1;
                    r.code = FMT_ALAW + {3'd0, st};
                end
                CODEC_ULAW: begin
                    r.ok   = 1'b1;
                    r.code = FMT_ULAW + {3'd0, st};
                end
                default: r = '0;
            endcase
        end
        return r;
    endfunction

    logic [3:0]  r_phase, n_phase, c_phase;
    logic [4:0]  r_pos,   n_pos,   c_pos;
    logic [31:0] r_shift, n_shift, c_shift;
    logic [31:0] r_chunk, n_chunk, c_chunk;
    logic [15:0] r_codec, n_codec, c_codec;
    logic [15:0] r_ext,   n_ext,   c_ext;
    logic [15:0] r_ch,    n_ch,    c_ch;
    logic [31:0] r_rate,  n_rate,  c_rate;
    logic [31:0] r_brate, n_brate, c_brate;
    logic [15:0] r_bits,  n_bits,  c_bits;
    logic [3:0]  r_fmt,   n_fmt,   c_fmt;
    logic        r_err,   n_err,   c_err;

    logic        restart;
    logic [7:0]  b;
    logic [4:0]  p_inc;
    logic [31:0] p_inc_w;
    logic        fmt_done;
    t_fmt_chk    chk;

    assign restart = i_accept && i_item.file_start;
    assign b       = i_item.in_byte;

    // a new file clears the whole context before this beat is parsed
    always_comb begin
        c_phase = restart ? PH_RIFF : r_phase;
        c_pos   = restart ? '0 : r_pos;
        c_shift = restart ? '0 : r_shift;
        c_chunk = restart ? '0 : r_chunk;
        c_codec = restart ? '0 : r_codec;
        c_ext   = restart ? '0 : r_ext;
        c_ch    = restart ? '0 : r_ch;
        c_rate  = restart ? '0 : r_rate;
        c_brate = restart ? '0 : r_brate;
        c_bits  = restart ? '0 : r_bits;
        c_fmt   = restart ? '0 : r_fmt;
        c_err   = restart ? 1'b0 : r_err;
    end

    assign p_inc   = c_pos + 5'd1;
    assign p_inc_w = {27'd0, p_inc};

    always_comb begin
        n_phase  = c_phase;
        n_pos    = c_pos;
        n_shift  = c_shift;
        n_chunk  = c_chunk;
        n_codec  = c_codec;
        n_ext    = c_ext;
        n_ch     = c_ch;
        n_rate   = c_rate;
        n_brate  = c_brate;
        n_bits   = c_bits;
        n_fmt    = c_fmt;
        n_err    = c_err;
        o_wr     = 1'b0;
        o_res    = '0;
        fmt_done = 1'b0;
        chk      = '0;

        if (i_accept && !c_err) begin
            unique case (c_phase)
                PH_RIFF, PH_WAVE: begin
                    n_shift = set32(c_shift, c_pos[1:0], b);
                    n_pos   = p_inc;
                    if (c_pos >= 5'd3) begin
                        n_pos = '0;
                        if (c_phase == PH_RIFF && n_shift != TAG_RIFF) begin
                            n_err             = 1'b1;
                            o_wr              = 1'b1;
                            o_res.result_kind = KIND_ERROR;
                            o_res.error_code  = ERR_NOT_RIFF;
                        end else if (c_phase == PH_WAVE && n_shift != TAG_WAVE) begin
                            n_err             = 1'b1;
                            o_wr              = 1'b1;
                            o_res.result_kind = KIND_ERROR;
                            o_res.error_code  = ERR_NOT_WAVE;
                        end else begin
                            n_phase = (c_phase == PH_RIFF) ? PH_RSIZE : PH_ID;
                            n_shift = '0;
                        end
                    end
                end
                PH_RSIZE: begin
                    n_pos = p_inc;
                    if (c_pos >= 5'd3) begin
                        n_pos   = '0;
                        n_phase = PH_WAVE;
                    end
                end
                PH_ID: begin
                    // chunk IDs are big-endian
                    n_shift = {c_shift[23:0], b};
                    n_pos   = p_inc;
                    if (c_pos >= 5'd3) begin
                        n_pos   = '0;
                        n_chunk = '0;
                        n_shift = '0;
                        if ({c_shift[23:0], b} == ID_FMT)       n_phase = PH_SZ_FMT;
                        else if ({c_shift[23:0], b} == ID_DATA) n_phase = PH_SZ_DATA;
                        else                                    n_phase = PH_SZ_OTHER;
                    end
                end
                PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER: begin
                    n_chunk = set32(c_chunk, c_pos[1:0], b);
                    n_pos   = p_inc;
                    if (c_pos >= 5'd3) begin
                        n_pos = '0;
                        if (c_phase == PH_SZ_FMT) begin
                            n_phase = PH_FMT;
                        end else if (c_phase == PH_SZ_OTHER) begin
                            n_phase = (n_chunk != '0) ? PH_SKIP : PH_ID;
                        end else begin
                            n_phase             = PH_DATA;
                            o_wr                = 1'b1;
                            o_res.result_kind   = KIND_HEADER;
                            o_res.format_code   = c_fmt;
                            o_res.channel_count = c_ch;
                            o_res.sample_rate   = c_rate;
                            o_res.byte_rate     = c_brate;
                            o_res.sample_bits   = c_bits;
                            o_res.data_length   = n_chunk;
                        end
                    end
                end
                PH_FMT: begin
                    if (c_pos < 5'd2) begin
                        n_codec = set16(c_codec, c_pos[0], b);
                    end else if (c_pos < 5'd4) begin
                        n_ch = set16(c_ch, c_pos[0], b);
                    end else if (c_pos < 5'd8) begin
                        n_rate = set32(c_rate, c_pos[1:0], b);
                    end else if (c_pos < 5'd12) begin
                        n_brate = set32(c_brate, c_pos[1:0], b);
                    end else if (c_pos < 5'd14) begin
                        // block align: not kept
                    end else if (c_pos < 5'd16) begin
                        n_bits = set16(c_bits, c_pos[0], b);
                    end else if (c_pos < 5'd18) begin
                        n_ext = set16(c_ext, c_pos[0], b);
                    end else if (c_pos < 5'd24) begin
                        // extension fields ahead of the sub-format: not kept
                    end else begin
                        // first two bytes of the sub-format GUID replace the codec
                        n_codec = set16(c_codec, c_pos[0], b);
                    end
                    fmt_done = (c_pos == 5'd15 && n_codec == CODEC_PCM)
                            || (c_pos == 5'd17 && n_ext != EXT_FULL)
                            || (c_pos >= 5'd25);
                    n_pos = p_inc;
                    if (fmt_done) begin
                        chk = classify(n_ch, n_codec, n_bits);
                        if (!chk.ok) begin
                            n_err             = 1'b1;
                            o_wr              = 1'b1;
                            o_res.result_kind = KIND_ERROR;
                            o_res.error_code  = ERR_FORMAT;
                        end else begin
                            n_fmt = chk.code;
                            n_pos = '0;
                            if (c_chunk > p_inc_w) begin
                                n_chunk = c_chunk - p_inc_w;
                                n_phase = PH_SKIP;
                            end else begin
                                n_chunk = '0;
                                n_phase = PH_ID;
                            end
                        end
                    end
                end
                PH_SKIP: begin
                    n_chunk = (c_chunk != '0) ? c_chunk - 32'd1 : c_chunk;
                    if (n_chunk == '0) begin
                        n_phase = PH_ID;
                        n_pos   = '0;
                    end
                end
                PH_DATA: begin
                    o_wr              = 1'b1;
                    o_res.result_kind = KIND_DATA;
                    o_res.data_byte   = b;
                end
                default: begin
                    n_phase = PH_RIFF;
                    n_pos   = '0;
                end
            endcase
        end else if (i_accept) begin
            // sticky error: only a restart leaves it
            n_err = c_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RIFF;
            r_pos   <= '0;
            r_shift <= '0;
            r_chunk <= '0;
            r_codec <= '0;
            r_ext   <= '0;
            r_ch    <= '0;
            r_rate  <= '0;
            r_brate <= '0;
            r_bits  <= '0;
            r_fmt   <= '0;
            r_err   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_shift <= n_shift;
            r_chunk <= n_chunk;
            r_codec <= n_codec;
            r_ext   <= n_ext;
            r_ch    <= n_ch;
            r_rate  <= n_rate;
            r_brate <= n_brate;
            r_bits  <= n_bits;
            r_fmt   <= n_fmt;
            r_err   <= n_err;
        end
    end

endmodule

[src/wavhp_queue.sv]
module wavhp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  wavhp_pkg::t_result  i_wdata,
    input  logic                i_rd,
    output wavhp_pkg::t_result  o_rdata,
    output wavhp_pkg::t_q_stat  o_stat
);
    import wavhp_pkg::*;

    t_result             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr, n_wptr;
    logic [QPTR_W-1:0]   r_rptr, n_rptr;
    logic [QCNT_W-1:0]   r_count, n_count;
    logic                do_wr, do_rd;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign do_wr        = i_wr && !o_stat.full;
    assign do_rd        = i_rd && !o_stat.empty;
    assign o_rdata      = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_wr) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_rd) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_wr && !do_rd)      n_count = r_count + 1'b1;
        else if (do_rd && !do_wr) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

[src/wavhp_out.sv]
module wavhp_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wavhp_pkg::t_q_stat  i_q_stat,
    input  wavhp_pkg::t_result  i_q_data,
    output logic                o_q_rd,
    output logic                o_empty,
    input  logic                i_pop,
    output wavhp_pkg::t_result  o_result
);
    import wavhp_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    // refill the output register whenever it is free or being taken
    assign o_q_rd   = !i_q_stat.empty && (!r_valid || i_pop);
    assign o_empty  = !r_valid;
    assign o_result = r_res;

    always_comb begin
        n_valid = r_valid;
        if (o_q_rd)            n_valid = 1'b1;
        else if (i_pop)        n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_res <= i_q_data;
        end
    end

endmodule

[src/wav_header_parser_core.sv]
// WAV header parser. Feed the file one byte per beat, with file_start set on
// its first byte; the block checks the RIFF/WAVE tags, walks the chunks, keeps
// the fmt values and, at the data chunk, returns one header result, then one
// data result per following byte. A bad tag or unsupported format returns a
// single error result and the block stays silent until the next file_start.
// Throughput is one byte per clock while full is low: the byte parser decides
// every byte combinationally, and its results pass through a four-entry queue
// to an output register. full only rises once four results sit unpopped behind
// the output register.
module wav_header_parser_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  wavhp_pkg::t_item    i_item,
    output logic                empty,
    input  logic                pop,
    output wavhp_pkg::t_result  o_result
);
    import wavhp_pkg::*;

    `include "wav_header_parser_core_assert.svh"

    logic    accept;
    logic    parser_wr;
    t_result parser_res;
    t_result q_data;
    t_q_stat q_stat;
    logic    q_rd;
    logic    out_not_hdr;
    logic    out_hdr_clear;

    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;

    wavhp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_wr     (parser_wr),
        .o_res    (parser_res)
    );

    wavhp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (parser_wr),
        .i_wdata (parser_res),
        .i_rd    (q_rd),
        .o_rdata (q_data),
        .o_stat  (q_stat)
    );

    wavhp_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_q_data (q_data),
        .o_q_rd   (q_rd),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );

    assign out_not_hdr   = !empty && (o_result.result_kind != KIND_HEADER);
    assign out_hdr_clear = (o_result.data_length == '0) && (o_result.format_code == '0);

    `WHP_ASSERT_IMP(a_no_write_when_full, parser_wr, !q_stat.full, "result written to full queue")
    `WHP_ASSERT_IMP(a_write_needs_beat, parser_wr, accept, "result without an accepted beat")
    `WHP_ASSERT_NXT(a_out_refills, empty && !q_stat.empty, !empty, "output not refilled")
    `WHP_ASSERT_IMP(a_non_header_clean, out_not_hdr, out_hdr_clear, "header fields on non-header")

endmodule

[tb/sv/wav_stream_checker.sv]
module wav_stream_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  wavhp_pkg::t_item   i_item,
    input  logic               i_empty,
    input  logic               i_pop,
    input  wavhp_pkg::t_result i_result,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import wavhp_pkg::*;

    localparam int PRINT_CAP = 40;

    typedef enum logic [3:0] {
        PH_RIFF_TAG,
        PH_RIFF_SIZE,
        PH_WAVE_TAG,
        PH_CHUNK_ID,
        PH_FMT_SIZE,
        PH_DATA_SIZE,
        PH_OTHER_SIZE,
        PH_FMT_BODY,
        PH_SKIP_BODY,
        PH_PAYLOAD
    } t_walk_phase;

    t_walk_phase walk_phase;
    logic [31:0] beat_idx;
    logic [31:0] tag_word;
    logic [31:0] chunk_remaining;
    logic [15:0] fmt_codec;
    logic [15:0] fmt_ext_len;
    logic [15:0] fmt_channels;
    logic [31:0] fmt_rate;
    logic [31:0] fmt_byterate;
    logic [15:0] fmt_bits;
    logic [3:0]  fmt_class;
    bit          error_latched;

    t_result     parsed_results_q[$];

    initial o_fail_count = 0;

    function automatic void clear_parse_state();
        walk_phase      = PH_RIFF_TAG;
        beat_idx        = '0;
        tag_word        = '0;
        chunk_remaining = '0;
        fmt_codec       = '0;
        fmt_ext_len     = '0;
        fmt_channels    = '0;
        fmt_rate        = '0;
        fmt_byterate    = '0;
        fmt_bits        = '0;
        fmt_class       = '0;
        error_latched   = 1'b0;
    endfunction

    function automatic bit classify_fmt(output logic [3:0] code);
        logic stereo;
        code = '0;
        if (fmt_channels == 16'd1) stereo = 1'b0;
        else if (fmt_channels == 16'd2) stereo = 1'b1;
        else return 1'b0;
        case (fmt_codec)
            CODEC_PCM: begin
                if (fmt_bits == 16'd8) code = stereo ? FMT_STEREO8 : FMT_MONO8;
                else if (fmt_bits == 16'd16) code = stereo ? FMT_STEREO16 : FMT_MONO16;
                else return 1'b0;
            end
            CODEC_FLOAT: begin
                if (fmt_bits != 16'd32) return 1'b0;
                code = FMT_F32 + stereo;
            end
            CODEC_ALAW: code = FMT_ALAW + stereo;
            CODEC_ULAW: code = FMT_ULAW + stereo;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic t_result error_beat(input logic [1:0] code);
        t_result r;
        r = '0;
        r.result_kind = KIND_ERROR;
        r.error_code  = code;
        error_latched = 1'b1;
        return r;
    endfunction

    function automatic void parse_wav_byte(input t_item it, output bit hit, output t_result res);
        logic [7:0]  b;
        logic [31:0] p;
        logic [3:0]  code;
        bit          done;
        b    = it.in_byte;
        hit  = 1'b0;
        res  = '0;
        done = 1'b0;
        if (it.file_start) clear_parse_state();
        if (error_latched) return;
        p = beat_idx;
        case (walk_phase)
            PH_RIFF_TAG, PH_WAVE_TAG: begin
                // tags are compared little-endian
                tag_word[8*p[1:0] +: 8] = b;
                beat_idx = p + 1;
                if (p >= 3) begin
                    beat_idx = '0;
                    if (walk_phase == PH_RIFF_TAG) begin
                        if (tag_word != TAG_RIFF) begin
                            hit = 1'b1;
                            res = error_beat(ERR_NOT_RIFF);
                            return;
                        end
                        walk_phase = PH_RIFF_SIZE;
                    end else begin
                        if (tag_word != TAG_WAVE) begin
                            hit = 1'b1;
                            res = error_beat(ERR_NOT_WAVE);
                            return;
                        end
                        walk_phase = PH_CHUNK_ID;
                    end
                    tag_word = '0;
                end
            end
            PH_RIFF_SIZE: begin
                beat_idx = p + 1;
                if (p >= 3) begin
                    beat_idx   = '0;
                    walk_phase = PH_WAVE_TAG;
                end
            end
            PH_CHUNK_ID: begin
                tag_word = {tag_word[23:0], b};
                beat_idx = p + 1;
                if (p >= 3) begin
                    beat_idx = '0;
                    if (tag_word == ID_FMT) walk_phase = PH_FMT_SIZE;
                    else if (tag_word == ID_DATA) walk_phase = PH_DATA_SIZE;
                    else walk_phase = PH_OTHER_SIZE;
                    tag_word        = '0;
                    chunk_remaining = '0;
                end
            end
            PH_FMT_SIZE, PH_DATA_SIZE, PH_OTHER_SIZE: begin
                chunk_remaining[8*p[1:0] +: 8] = b;
                beat_idx = p + 1;
                if (p >= 3) begin
                    beat_idx = '0;
                    if (walk_phase == PH_FMT_SIZE) begin
                        walk_phase = PH_FMT_BODY;
                    end else if (walk_phase == PH_OTHER_SIZE) begin
                        walk_phase = (chunk_remaining != 0) ? PH_SKIP_BODY : PH_CHUNK_ID;
                    end else begin
                        walk_phase        = PH_PAYLOAD;
                        hit               = 1'b1;
                        res.result_kind   = KIND_HEADER;
                        res.format_code   = fmt_class;
                        res.channel_count = fmt_channels;
                        res.sample_rate   = fmt_rate;
                        res.byte_rate     = fmt_byterate;
                        res.sample_bits   = fmt_bits;
                        res.data_length   = chunk_remaining;
                    end
                end
            end
            PH_FMT_BODY: begin
                if (p < 2) fmt_codec[8*p[0] +: 8] = b;
                else if (p < 4) fmt_channels[8*p[0] +: 8] = b;
                else if (p < 8) fmt_rate[8*p[1:0] +: 8] = b;
                else if (p < 12) fmt_byterate[8*p[1:0] +: 8] = b;
                else if (p >= 14 && p < 16) fmt_bits[8*p[0] +: 8] = b;
                else if (p >= 16 && p < 18) fmt_ext_len[8*p[0] +: 8] = b;
                else if (p >= 24) fmt_codec[8*p[0] +: 8] = b;  // sub-format replaces codec
                if (p == 15 && fmt_codec == CODEC_PCM) done = 1'b1;
                else if (p == 17 && fmt_ext_len != EXT_FULL) done = 1'b1;
                else if (p >= 25) done = 1'b1;
                beat_idx = p + 1;
                if (!done) return;
                if (!classify_fmt(code)) begin
                    hit = 1'b1;
                    res = error_beat(ERR_FORMAT);
                    return;
                end
                fmt_class = code;
                beat_idx  = '0;
                if (chunk_remaining > p + 1) begin
                    chunk_remaining = chunk_remaining - (p + 1);
                    walk_phase      = PH_SKIP_BODY;
                end else begin
                    chunk_remaining = '0;
                    walk_phase      = PH_CHUNK_ID;
                end
            end
            PH_SKIP_BODY: begin
                if (chunk_remaining > 0) chunk_remaining = chunk_remaining - 1;
                if (chunk_remaining == 0) begin
                    walk_phase = PH_CHUNK_ID;
                    beat_idx   = '0;
                end
            end
            PH_PAYLOAD: begin
                hit             = 1'b1;
                res.result_kind = KIND_DATA;
                res.data_byte   = b;
            end
            default: begin
                walk_phase = PH_RIFF_TAG;
                beat_idx   = '0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        o_fail_count++;
        if (o_fail_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic compare_result(input t_result got, input t_result want);
        if (got.result_kind !== want.result_kind)
            report_mismatch($sformatf("result_kind got %0d want %0d",
                                      got.result_kind, want.result_kind));
        if (got.format_code !== want.format_code)
            report_mismatch($sformatf("format_code got %0d want %0d",
                                      got.format_code, want.format_code));
        if (got.channel_count !== want.channel_count)
            report_mismatch($sformatf("channel_count got %0h want %0h",
                                      got.channel_count, want.channel_count));
        if (got.sample_rate !== want.sample_rate)
            report_mismatch($sformatf("sample_rate got %0h want %0h",
                                      got.sample_rate, want.sample_rate));
        if (got.byte_rate !== want.byte_rate)
            report_mismatch($sformatf("byte_rate got %0h want %0h",
                                      got.byte_rate, want.byte_rate));
        if (got.sample_bits !== want.sample_bits)
            report_mismatch($sformatf("sample_bits got %0h want %0h",
                                      got.sample_bits, want.sample_bits));
        if (got.data_length !== want.data_length)
            report_mismatch($sformatf("data_length got %0h want %0h",
                                      got.data_length, want.data_length));
        if (got.data_byte !== want.data_byte)
            report_mismatch($sformatf("data_byte got %0h want %0h",
                                      got.data_byte, want.data_byte));
        if (got.error_code !== want.error_code)
            report_mismatch($sformatf("error_code got %0d want %0d",
                                      got.error_code, want.error_code));
    endtask

    always @(posedge i_clk) begin : watch
        t_result predicted;
        bit      produced;
        if (!i_rst_n) begin
            clear_parse_state();
            parsed_results_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (parsed_results_q.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                    compare_result(i_result, parsed_results_q.pop_front());
            end
            if (i_push && !i_full) begin
                parse_wav_byte(i_item, produced, predicted);
                if (produced) parsed_results_q.push_back(predicted);
            end
        end
        o_pending <= parsed_results_q.size();
    end

endmodule

[tb/sv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wavhp_pkg::*;

    localparam int          RANDOM_BEATS     = 1550;
    localparam int          CYCLE_LIMIT      = 300000;
    localparam int          DRAIN_CYCLES     = 20;
    localparam logic [15:0] CODEC_EXTENSIBLE = 16'hFFFE;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    push    = 1'b0;
    logic    pop     = 1'b0;
    t_item   i_item  = '0;
    logic    full;
    logic    empty;
    t_result o_result;

    int mismatch_total;
    int results_outstanding;
    int send_idle_pct = 8;
    int recv_idle_pct = 63;
    int beats_sent    = 0;
    int cycle_count   = 0;

    logic [7:0] wav_bytes[$];

    always #5 i_clk = ~i_clk;

    wav_header_parser_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    wav_stream_checker beat_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (i_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (o_result),
        .o_fail_count (mismatch_total),
        .o_pending    (results_outstanding)
    );

    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void put_le16(input logic [15:0] v);
        wav_bytes.push_back(v[7:0]);
        wav_bytes.push_back(v[15:8]);
    endfunction

    function automatic void put_le32(input logic [31:0] v);
        put_le16(v[15:0]);
        put_le16(v[31:16]);
    endfunction

    function automatic void put_id_be(input logic [31:0] v);
        wav_bytes.push_back(v[31:24]);
        wav_bytes.push_back(v[23:16]);
        wav_bytes.push_back(v[15:8]);
        wav_bytes.push_back(v[7:0]);
    endfunction

    function automatic void begin_file(input logic [31:0] riff_tag, input logic [31:0] wave_tag);
        wav_bytes.delete();
        put_le32(riff_tag);
        put_le32($urandom);
        put_le32(wave_tag);
    endfunction

    function automatic void add_fmt(input logic [15:0] codec, input logic [15:0] chans,
                                    input logic [15:0] bits, input logic [31:0] rate,
                                    input logic [31:0] brate, input logic [15:0] ext_len,
                                    input logic [15:0] sub_codec, input int tail,
                                    input bit short_size);
        logic [7:0] body[$];
        logic [7:0] hold[$];
        int         declared;
        hold      = wav_bytes;
        wav_bytes = {};
        put_le16(codec);
        put_le16(chans);
        put_le32(rate);
        put_le32(brate);
        put_le16(16'($urandom));
        put_le16(bits);
        if (codec != CODEC_PCM) begin
            put_le16(ext_len);
            if (ext_len == EXT_FULL) begin
                repeat (6) wav_bytes.push_back(8'($urandom));
                put_le16(sub_codec);
                repeat (14) wav_bytes.push_back(8'($urandom));
            end
        end
        repeat (tail) wav_bytes.push_back(8'($urandom));
        body      = wav_bytes;
        wav_bytes = hold;
        // a short size field still gets the fields read in full
        declared  = short_size ? $urandom_range(body.size() - 1) : body.size();
        put_id_be(ID_FMT);
        put_le32(declared);
        foreach (body[k]) wav_bytes.push_back(body[k]);
    endfunction

    function automatic void add_junk();
        logic [31:0] id;
        int          len;
        id = $urandom;
        while (id == ID_FMT || id == ID_DATA) id = $urandom;
        len = $urandom_range(7);
        put_id_be(id);
        put_le32(len);
        repeat (len) wav_bytes.push_back(8'($urandom));
    endfunction

    function automatic void add_data(input logic [31:0] len, input int nbytes);
        put_id_be(ID_DATA);
        put_le32(len);
        for (int k = 0; k < nbytes; k++)
            wav_bytes.push_back(k == 0 ? 8'h00 : (k == 1 ? 8'hFF : 8'($urandom)));
    endfunction

    function automatic void add_random_fmt(input bit supported);
        logic [15:0] codec;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [15:0] ext_len;
        logic [15:0] sub_codec;
        int          tail;
        chans = 16'($urandom_range(1, 2));
        case ($urandom_range(3))
            0: begin
                codec = CODEC_PCM;
                bits  = $urandom_range(1) ? 16'd16 : 16'd8;
            end
            1: begin
                codec = CODEC_FLOAT;
                bits  = 16'd32;
            end
            2: begin
                codec = CODEC_ALAW;
                bits  = 16'($urandom);
            end
            default: begin
                codec = CODEC_ULAW;
                bits  = 16'($urandom);
            end
        endcase
        if (!supported) begin
            case ($urandom_range(3))
                0: chans = $urandom_range(1) ? 16'd0 : 16'($urandom_range(3, 65535));
                1: begin
                    codec = CODEC_PCM;
                    bits  = 16'd24;
                end
                2: begin
                    codec = CODEC_FLOAT;
                    bits  = 16'd64;
                end
                default: begin
                    codec = 16'($urandom);
                    if (codec == CODEC_PCM || codec == CODEC_FLOAT ||
                        codec == CODEC_ALAW || codec == CODEC_ULAW)
                        codec = 16'h0055;
                end
            endcase
        end
        ext_len   = '0;
        sub_codec = '0;
        if ($urandom_range(2) == 0) begin
            sub_codec = codec;
            codec     = CODEC_EXTENSIBLE;
            ext_len   = EXT_FULL;
        end else if (codec != CODEC_PCM) begin
            ext_len   = $urandom_range(1) ? 16'd0 : 16'($urandom);
            sub_codec = codec;
        end
        tail = ($urandom_range(3) == 0) ? $urandom_range(1, 9) : 0;
        add_fmt(codec, chans, bits, $urandom, $urandom, ext_len, sub_codec, tail,
                tail == 0 && $urandom_range(7) == 0);
    endfunction

    task automatic send_beat(input logic [7:0] b, input bit start);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= '{in_byte: b, file_start: start};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic play_file(input int keep);
        for (int k = 0; k < wav_bytes.size() && k < keep; k++)
            send_beat(wav_bytes[k], k == 0);
    endtask

    task automatic wait_for_drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (results_outstanding != 0) @(posedge i_clk);
    endtask

    task automatic run_random_file();
        int shape;
        shape = $urandom_range(99);
        if (shape < 4) begin
            // noise with stray file starts
            repeat ($urandom_range(1, 12)) send_beat(8'($urandom), $urandom_range(9) < 3);
            return;
        end
        if (shape < 7)
            begin_file(TAG_RIFF ^ (32'd1 << $urandom_range(31)), TAG_WAVE);
        else if (shape < 10)
            begin_file(TAG_RIFF, TAG_WAVE ^ (32'd1 << $urandom_range(31)));
        else
            begin_file(TAG_RIFF, TAG_WAVE);
        repeat ($urandom_range(2)) add_junk();
        if (shape >= 13) add_random_fmt(shape >= 18);
        if ($urandom_range(6) == 0) begin
            if ($urandom_range(1)) add_junk();
            add_random_fmt(1'b1);
        end
        case ($urandom_range(3))
            0: add_data(32'd0, $urandom_range(32));
            1: add_data('1, $urandom_range(32));
            default: add_data($urandom, $urandom_range(32));
        endcase
        play_file(($urandom_range(19) == 0) ? $urandom_range(1, wav_bytes.size())
                                             : wav_bytes.size());
    endtask

    initial begin
        bit paused;
        paused = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bad RIFF tag, then beats swallowed by the sticky error
        begin_file(32'h5846_4952, TAG_WAVE);
        play_file(8);
        begin_file(TAG_RIFF, TAG_WAVE ^ 32'h0000_0100);
        play_file(16);
        // extremes of the rate fields and of the data length
        begin_file(TAG_RIFF, TAG_WAVE);
        add_fmt(CODEC_PCM, 16'd1, 16'd8, 32'd0, '1, 16'd0, 16'd0, 0, 1'b0);
        add_data('1, 3);
        play_file(wav_bytes.size());
        // data chunk before any fmt: zero header
        begin_file(TAG_RIFF, TAG_WAVE);
        add_junk();
        add_data(32'd0, 1);
        play_file(wav_bytes.size());
        // extensible mu-law, then a repeated fmt with a short size field
        begin_file(TAG_RIFF, TAG_WAVE);
        add_fmt(CODEC_EXTENSIBLE, 16'd2, 16'd8, $urandom, $urandom, EXT_FULL, CODEC_ULAW,
                0, 1'b0);
        add_fmt(CODEC_PCM, 16'd2, 16'd16, '1, 32'd0, 16'd0, 16'd0, 0, 1'b1);
        add_data($urandom, 2);
        play_file(wav_bytes.size());
        // float with fmt tail to skip, plain a-law
        begin_file(TAG_RIFF, TAG_WAVE);
        add_fmt(CODEC_FLOAT, 16'd2, 16'd32, $urandom, $urandom, 16'd0, 16'd0, 5, 1'b0);
        add_junk();
        add_data($urandom, 1);
        play_file(wav_bytes.size());
        begin_file(TAG_RIFF, TAG_WAVE);
        add_fmt(CODEC_ALAW, 16'd1, 16'd8, $urandom, $urandom, 16'd0, 16'd0, 0, 1'b0);
        add_data($urandom, 1);
        play_file(wav_bytes.size());
        // 24-bit PCM is unsupported
        begin_file(TAG_RIFF, TAG_WAVE);
        add_fmt(CODEC_PCM, 16'd1, 16'd24, $urandom, $urandom, 16'd0, 16'd0, 0, 1'b0);
        add_data($urandom, 2);
        play_file(wav_bytes.size());

        while (beats_sent < RANDOM_BEATS) begin
            if (beats_sent >= 2 * RANDOM_BEATS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (beats_sent >= RANDOM_BEATS / 3) begin
                send_idle_pct = 63;
                recv_idle_pct = 8;
            end else begin
                send_idle_pct = 8;
                recv_idle_pct = 63;
            end
            run_random_file();
            if (!paused && beats_sent >= RANDOM_BEATS / 2) begin
                paused = 1'b1;
                wait_for_drain();
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_total == 0 && results_outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
